/* hw/rtl/fgd_pkg.sv */
// Shared types and constants for the frame rate reduce-motion guard.
package fgd_pkg;

   localparam int FPS_W       = 16;
   localparam int THR_W       = 14;
   localparam int CFG_W       = 10;
   localparam int REDUCE_W    = 36;
   localparam int CSR_INDEX_W = 2;

   // 16e9 ns, fps times 16
   localparam logic [33:0] NS_X16  = 34'd16000000000;
   localparam logic [33:0] TEN_E10 = 34'd10000000000;
   // intervals at or below this give a saturated fps
   localparam logic [17:0] FPS_SAT_D = 18'd244140;
   localparam logic [FPS_W-1:0] FPS_MAX = 16'hFFFF;

   localparam logic [REDUCE_W-1:0] REDUCE_AFTER_RESET = 36'd2000000000;
   localparam logic [REDUCE_W-1:0] RECOVERY_MIN       = 36'd200000000;
   localparam logic [REDUCE_W-1:0] RECOVERY_DEFAULT   = 36'd300000000;

   localparam logic [CFG_W-1:0] FPS_TARGET_RESET = 10'd60;
   localparam logic [CFG_W-1:0] TGT_HIGH         = 10'd120;
   localparam logic [CFG_W-1:0] TGT_MID          = 10'd90;
   localparam logic [CFG_W-1:0] TGT_LOW          = 10'd60;
   localparam logic [CFG_W-1:0] TGT_STEP         = 10'd10;

   localparam logic [THR_W-1:0] THR_HIGH  = 14'd1100;
   localparam logic [THR_W-1:0] THR_MID   = 14'd550;
   localparam logic [THR_W-1:0] THR_FLOOR = 14'd300;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FPS_TARGET       = 2'd0,
      CSR_LOW_FPS_OVERRIDE = 2'd1,
      CSR_REDUCE_AFTER_NS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             low;
      logic [FPS_W-1:0] fps;
   } ser_status_type;

   typedef struct packed {
      logic valid;
      logic low;
   } dwell_req_type;

   typedef struct packed {
      logic reduce;
      logic changed;
   } dwell_flags_type;

endpackage

/* hw/rtl/fgd_serial.sv */
// Bit-serial fps divider and threshold multiplier, one quotient bit per cycle.
module fgd_serial #(
   parameter int TIME_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [TIME_BITS-1:0]          d,
   input  logic [fgd_pkg::THR_W-1:0]     thr10,
   output fgd_pkg::ser_status_type       status
);

   localparam int STEPS = fgd_pkg::FPS_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam int ACC_W = TIME_BITS + STEPS;

   logic                 busy_ff;
   logic                 fin_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [TIME_BITS-1:0] div_ff;
   logic [TIME_BITS-1:0] rem_ff;
   logic [STEPS-1:0]     num_ff;
   logic [STEPS-1:0]     quo_ff;
   logic [STEPS-1:0]     thr_ff;
   logic [ACC_W-1:0]     acc_ff;

   logic [TIME_BITS:0]   trial;
   logic                 ge;
   logic [TIME_BITS:0]   rem_in;
   logic [ACC_W-1:0]     acc_in;

   always_comb begin
      trial  = {rem_ff, num_ff[STEPS-1]};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? (trial - {1'b0, div_ff}) : trial;
      acc_in = {acc_ff[ACC_W-2:0], 1'b0}
               + (thr_ff[STEPS-1] ? ACC_W'(div_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         fin_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= d;
         rem_ff <= TIME_BITS'(fgd_pkg::NS_X16[33:16]);
         num_ff <= fgd_pkg::NS_X16[15:0];
         quo_ff <= '0;
         thr_ff <= STEPS'(thr10);
         acc_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= rem_in[TIME_BITS-1:0];
         num_ff <= {num_ff[STEPS-2:0], 1'b0};
         quo_ff <= {quo_ff[STEPS-2:0], ge};
         thr_ff <= {thr_ff[STEPS-2:0], 1'b0};
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      status.busy = busy_ff;
      status.done = fin_ff;
      status.low  = acc_ff > ACC_W'(fgd_pkg::TEN_E10);
      status.fps  = (div_ff <= TIME_BITS'(fgd_pkg::FPS_SAT_D)) ? fgd_pkg::FPS_MAX : quo_ff;
   end

endmodule

/* hw/rtl/fgd_dwell.sv */
// Low and high dwell accumulators and the reduce-motion flag.
module fgd_dwell #(
   parameter int TIME_BITS  = 48,
   parameter int DWELL_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  fgd_pkg::dwell_req_type        req,
   input  logic [TIME_BITS-1:0]          d,
   input  logic [fgd_pkg::REDUCE_W-1:0]  reduce_after,
   output fgd_pkg::dwell_flags_type      flags
);

   localparam int SW = ((TIME_BITS > DWELL_BITS) ? TIME_BITS : DWELL_BITS) + 1;
   localparam int CW = (DWELL_BITS > fgd_pkg::REDUCE_W) ? DWELL_BITS : fgd_pkg::REDUCE_W;
   localparam logic [DWELL_BITS-1:0] DWELL_MAX = '1;

   logic [DWELL_BITS-1:0]        low_dwell_ff;
   logic [DWELL_BITS-1:0]        high_dwell_ff;
   logic                         reduce_ff;
   logic                         changed_ff;

   logic [SW-1:0]                sum;
   logic [DWELL_BITS-1:0]        dwell_in;
   logic [fgd_pkg::REDUCE_W:0]   half_sum;
   logic [fgd_pkg::REDUCE_W-1:0] recovery;
   logic                         set_hit;
   logic                         clr_hit;
   logic                         reduce_in;

   always_comb begin
      sum      = SW'(req.low ? low_dwell_ff : high_dwell_ff) + SW'(d);
      dwell_in = (sum >= SW'(DWELL_MAX)) ? DWELL_MAX : sum[DWELL_BITS-1:0];
      half_sum = ({1'b0, reduce_after} + 1'b1) >> 1;
      if (reduce_after == '0) begin
         recovery = fgd_pkg::RECOVERY_DEFAULT;
      end else if (half_sum[fgd_pkg::REDUCE_W-1:0] < fgd_pkg::RECOVERY_MIN) begin
         recovery = fgd_pkg::RECOVERY_MIN;
      end else begin
         recovery = half_sum[fgd_pkg::REDUCE_W-1:0];
      end
      set_hit   = (reduce_after == '0) || (CW'(dwell_in) >= CW'(reduce_after));
      clr_hit   = CW'(dwell_in) >= CW'(recovery);
      reduce_in = req.low ? (reduce_ff | set_hit) : (reduce_ff & ~clr_hit);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         low_dwell_ff  <= '0;
         high_dwell_ff <= '0;
         reduce_ff     <= 1'b0;
         changed_ff    <= 1'b0;
      end else if (req.valid) begin
         low_dwell_ff  <= req.low ? dwell_in : '0;
         high_dwell_ff <= req.low ? '0 : dwell_in;
         reduce_ff     <= reduce_in;
         changed_ff    <= reduce_in ^ reduce_ff;
      end
   end

   assign flags.reduce  = reduce_ff;
   assign flags.changed = changed_ff;

   a_rise_on_low : assert property (@(posedge clock) disable iff (reset)
      $rose(reduce_ff) |-> $past(req.valid && req.low && !clear))
      else $error("reduce set without a low frame");

   a_fall_on_high : assert property (@(posedge clock) disable iff (reset)
      $fell(reduce_ff) |-> $past(clear || (req.valid && !req.low)))
      else $error("reduce cleared without a high frame or clear");

endmodule

/* hw/rtl/frame_rate_reduce_motion_guard_unit.sv */
// Top level: frame-rate guard with timestamp tracking, config registers and result register.
// An accepted beat with a nonzero interval runs the 16-step serial divider/multiplier in
// S_RUN, then waits in S_OUT until the result register loads; req_ready is low meanwhile.
// Beats that only record the time (first after reset or config, zero interval) stay idle.
// Reset: config returns to 60 fps target, no override, 2 s dwell; tracking state clears.
// No clearing pass after reset; writes to the three config registers also clear tracking.
module frame_rate_reduce_motion_guard_unit #(
   parameter int TIME_BITS  = 48,
   parameter int DWELL_BITS = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [TIME_BITS-1:0]               req_timestamp_ns,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fgd_pkg::FPS_W-1:0]          rsp_fps_x16,
   output logic                               rsp_low_frame,
   output logic                               rsp_reduce_motion,
   output logic                               rsp_changed,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fgd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fgd_pkg::REDUCE_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_OUT
   } state_type;

   state_type                       state_ff;
   logic [fgd_pkg::CFG_W-1:0]       fps_target_ff;
   logic [fgd_pkg::CFG_W-1:0]       override_ff;
   logic [fgd_pkg::REDUCE_W-1:0]    reduce_after_ff;
   logic [TIME_BITS-1:0]            last_time_ff;
   logic                            time_valid_ff;
   logic [TIME_BITS-1:0]            d_ff;
   logic                            rsp_valid_ff;
   logic [fgd_pkg::FPS_W-1:0]       rsp_fps_ff;
   logic                            rsp_low_ff;
   logic                            rsp_reduce_ff;
   logic                            rsp_changed_ff;

   fgd_pkg::csr_index_type          csr_sel;
   logic                            csr_we;
   logic                            cfg_clear;
   logic                            accept;
   logic [TIME_BITS-1:0]            d_in;
   logic                            start;
   logic                            load;
   logic [fgd_pkg::THR_W-1:0]       ovr_w;
   logic [fgd_pkg::THR_W-1:0]       tgt_w;
   logic [fgd_pkg::THR_W-1:0]       tgt_m10;
   logic [fgd_pkg::THR_W-1:0]       tgt_x9;
   logic [fgd_pkg::THR_W-1:0]       thr10;
   fgd_pkg::ser_status_type         ser;
   fgd_pkg::dwell_req_type          dwell_req;
   fgd_pkg::dwell_flags_type        flags;

   // config write wins over a frame beat in the same cycle
   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE);
   assign csr_sel   = fgd_pkg::csr_index_type'(csr_index);
   assign csr_we    = csr_valid && csr_ready;
   assign cfg_clear = csr_we && ((csr_sel == fgd_pkg::CSR_FPS_TARGET)
                                 || (csr_sel == fgd_pkg::CSR_LOW_FPS_OVERRIDE)
                                 || (csr_sel == fgd_pkg::CSR_REDUCE_AFTER_NS));
   assign accept    = req_valid && req_ready;
   assign d_in      = req_timestamp_ns - last_time_ff;
   assign start     = accept && time_valid_ff && (d_in != '0);
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   assign dwell_req.valid = (state_ff == S_RUN) && ser.done;
   assign dwell_req.low   = ser.low;

   // threshold in tenths of fps
   always_comb begin
      ovr_w   = fgd_pkg::THR_W'(override_ff);
      tgt_w   = fgd_pkg::THR_W'(fps_target_ff);
      tgt_m10 = tgt_w - fgd_pkg::THR_W'(fgd_pkg::TGT_STEP);
      tgt_x9  = (tgt_w << 3) + tgt_w;
      if (override_ff != '0) begin
         thr10 = (ovr_w << 3) + (ovr_w << 1);
      end else if (fps_target_ff >= fgd_pkg::TGT_HIGH) begin
         thr10 = fgd_pkg::THR_HIGH;
      end else if (fps_target_ff >= fgd_pkg::TGT_MID) begin
         thr10 = (tgt_m10 << 3) + (tgt_m10 << 1);
      end else if (fps_target_ff >= fgd_pkg::TGT_LOW) begin
         thr10 = fgd_pkg::THR_MID;
      end else begin
         thr10 = (tgt_x9 < fgd_pkg::THR_FLOOR) ? fgd_pkg::THR_FLOOR : tgt_x9;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_target_ff   <= fgd_pkg::FPS_TARGET_RESET;
         override_ff     <= '0;
         reduce_after_ff <= fgd_pkg::REDUCE_AFTER_RESET;
      end else if (csr_we) begin
         case (csr_sel)
            fgd_pkg::CSR_FPS_TARGET: begin
               fps_target_ff <= csr_wdata[fgd_pkg::CFG_W-1:0];
            end
            fgd_pkg::CSR_LOW_FPS_OVERRIDE: begin
               override_ff <= csr_wdata[fgd_pkg::CFG_W-1:0];
            end
            fgd_pkg::CSR_REDUCE_AFTER_NS: begin
               reduce_after_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         time_valid_ff <= 1'b0;
         last_time_ff  <= '0;
      end else if (accept) begin
         time_valid_ff <= 1'b1;
         last_time_ff  <= req_timestamp_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               if (ser.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (load) begin
            rsp_valid_ff   <= 1'b1;
            rsp_fps_ff     <= ser.fps;
            rsp_low_ff     <= ser.low;
            rsp_reduce_ff  <= flags.reduce;
            rsp_changed_ff <= flags.changed;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fps_x16       = rsp_fps_ff;
   assign rsp_low_frame     = rsp_low_ff;
   assign rsp_reduce_motion = rsp_reduce_ff;
   assign rsp_changed       = rsp_changed_ff;

   fgd_serial #(
      .TIME_BITS (TIME_BITS)
   ) u_serial (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .d      (d_in),
      .thr10  (thr10),
      .status (ser)
   );

   fgd_dwell #(
      .TIME_BITS  (TIME_BITS),
      .DWELL_BITS (DWELL_BITS)
   ) u_dwell (
      .clock        (clock),
      .reset        (reset),
      .clear        (cfg_clear),
      .req          (dwell_req),
      .d            (d_ff),
      .reduce_after (reduce_after_ff),
      .flags        (flags)
   );

   a_run_tracks_serial : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (ser.busy || ser.done))
      else $error("run state without serial work");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result loaded outside output state");

endmodule

/* verif/frame_rate_reduce_motion_guard_unit_tb.sv */
// Testbench for frame_rate_reduce_motion_guard_unit: random frame timing checked against a predictor.
`timescale 1ns / 1ps

module frame_rate_reduce_motion_guard_unit_tb;

   localparam int TIME_BITS       = 48;
   localparam int DWELL_BITS      = 40;
   localparam int N_SETTINGS      = 8;
   localparam int PHASE_BEATS     = 104;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;

   localparam logic [fgd_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [DWELL_BITS-1:0]  DWELL_MAX  = {DWELL_BITS{1'b1}};

   localparam logic [fgd_pkg::CFG_W-1:0] TARGET_SET [N_SETTINGS] =
      '{10'd60, 10'd0, 10'd1023, 10'd95, 10'd120, 10'd30, 10'd90, 10'd59};
   localparam logic [fgd_pkg::CFG_W-1:0] OVERRIDE_SET [N_SETTINGS] =
      '{10'd0, 10'd0, 10'd0, 10'd0, 10'd1000, 10'd1, 10'd1023, 10'd0};
   localparam logic [fgd_pkg::REDUCE_W-1:0] REDUCE_SET [N_SETTINGS] =
      '{36'd2000000000, 36'd0, 36'hF_FFFF_FFFF, 36'd100000000,
        36'd60000000000, 36'd1, 36'd500000000, 36'd3000000000};

   typedef enum int {RUN_LOW, RUN_HIGH, RUN_NOISE} run_kind_type;

   typedef struct {
      logic [fgd_pkg::FPS_W-1:0] fps_x16;
      logic                      low_frame;
      logic                      reduce_motion;
      logic                      changed;
   } frame_verdict_type;

   class reduce_motion_tracker;
      logic [fgd_pkg::CFG_W-1:0]    fps_target;
      logic [fgd_pkg::CFG_W-1:0]    low_fps_override;
      logic [fgd_pkg::REDUCE_W-1:0] reduce_after_ns;
      logic [TIME_BITS-1:0]         last_time;
      bit                           time_valid;
      logic [DWELL_BITS-1:0]        low_dwell;
      logic [DWELL_BITS-1:0]        high_dwell;
      bit                           reduce_active;
      frame_verdict_type            expected_verdicts[$];
      int unsigned                  mismatches;

      function new();
         fps_target       = fgd_pkg::FPS_TARGET_RESET;
         low_fps_override = '0;
         reduce_after_ns  = fgd_pkg::REDUCE_AFTER_RESET;
         mismatches       = 0;
         clear_tracking();
      endfunction

      function void clear_tracking();
         last_time     = '0;
         time_valid    = 1'b0;
         low_dwell     = '0;
         high_dwell    = '0;
         reduce_active = 1'b0;
      endfunction

      function longint unsigned threshold_tenths();
         longint unsigned t;
         if (low_fps_override != 0) return 64'(low_fps_override) * 10;
         if (fps_target >= fgd_pkg::TGT_HIGH) return 64'(fgd_pkg::THR_HIGH);
         if (fps_target >= fgd_pkg::TGT_MID)
            return (64'(fps_target) - 64'(fgd_pkg::TGT_STEP)) * 10;
         if (fps_target >= fgd_pkg::TGT_LOW) return 64'(fgd_pkg::THR_MID);
         t = 64'(fps_target) * 9;
         return (t < 64'(fgd_pkg::THR_FLOOR)) ? 64'(fgd_pkg::THR_FLOOR) : t;
      endfunction

      function logic [DWELL_BITS-1:0] dwell_add(logic [DWELL_BITS-1:0] acc,
                                                logic [TIME_BITS-1:0] d);
         logic [TIME_BITS:0] sum;
         sum = {1'b0, d} + (TIME_BITS+1)'(acc);
         if (sum >= (TIME_BITS+1)'(DWELL_MAX)) return DWELL_MAX;
         return sum[DWELL_BITS-1:0];
      endfunction

      function void write_reg(logic [fgd_pkg::CSR_INDEX_W-1:0] idx,
                              logic [fgd_pkg::REDUCE_W-1:0] data);
         case (idx)
            fgd_pkg::CSR_FPS_TARGET:       fps_target       = data[fgd_pkg::CFG_W-1:0];
            fgd_pkg::CSR_LOW_FPS_OVERRIDE: low_fps_override = data[fgd_pkg::CFG_W-1:0];
            fgd_pkg::CSR_REDUCE_AFTER_NS:  reduce_after_ns  = data;
            default:                       return;
         endcase
         clear_tracking();
      endfunction

      function void note_frame(logic [TIME_BITS-1:0] ts);
         logic [TIME_BITS-1:0] d;
         longint unsigned      rate;
         longint unsigned      recovery;
         bit                   low;
         bit                   prior;
         frame_verdict_type    v;
         if (!time_valid) begin
            last_time  = ts;
            time_valid = 1'b1;
            return;
         end
         d         = ts - last_time;
         last_time = ts;
         if (d == 0) return;
         rate = 64'(fgd_pkg::NS_X16) / 64'(d);
         if (rate > 64'(fgd_pkg::FPS_MAX)) rate = 64'(fgd_pkg::FPS_MAX);
         low   = 64'(d) > (64'(fgd_pkg::TEN_E10) / threshold_tenths());
         prior = reduce_active;
         if (low) begin
            low_dwell  = dwell_add(low_dwell, d);
            high_dwell = '0;
            if (!reduce_active && (reduce_after_ns == 0 || low_dwell >= reduce_after_ns))
               reduce_active = 1'b1;
         end else begin
            high_dwell = dwell_add(high_dwell, d);
            low_dwell  = '0;
            if (reduce_after_ns != 0) begin
               recovery = (64'(reduce_after_ns) + 1) / 2;
               if (recovery < 64'(fgd_pkg::RECOVERY_MIN))
                  recovery = 64'(fgd_pkg::RECOVERY_MIN);
            end else begin
               recovery = 64'(fgd_pkg::RECOVERY_DEFAULT);
            end
            if (reduce_active && 64'(high_dwell) >= recovery) reduce_active = 1'b0;
         end
         v.fps_x16       = rate[fgd_pkg::FPS_W-1:0];
         v.low_frame     = low;
         v.reduce_motion = reduce_active;
         v.changed       = reduce_active != prior;
         expected_verdicts.push_back(v);
      endfunction

      function void check_result(logic [fgd_pkg::FPS_W-1:0] fps_x16, logic low_frame,
                                 logic reduce_motion, logic changed);
         frame_verdict_type v;
         if (expected_verdicts.size() == 0) begin
            $error("unexpected rsp beat: fps_x16 %0d", fps_x16);
            mismatches++;
            return;
         end
         v = expected_verdicts.pop_front();
         if (fps_x16 !== v.fps_x16) begin
            $error("fps_x16 expected %0d actual %0d", v.fps_x16, fps_x16);
            mismatches++;
         end
         if (low_frame !== v.low_frame) begin
            $error("low_frame expected %0d actual %0d", v.low_frame, low_frame);
            mismatches++;
         end
         if (reduce_motion !== v.reduce_motion) begin
            $error("reduce_motion expected %0d actual %0d", v.reduce_motion, reduce_motion);
            mismatches++;
         end
         if (changed !== v.changed) begin
            $error("changed expected %0d actual %0d", v.changed, changed);
            mismatches++;
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [TIME_BITS-1:0]              req_timestamp_ns;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [fgd_pkg::FPS_W-1:0]         rsp_fps_x16;
   logic                              rsp_low_frame;
   logic                              rsp_reduce_motion;
   logic                              rsp_changed;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [fgd_pkg::CSR_INDEX_W-1:0]   csr_index;
   logic [fgd_pkg::REDUCE_W-1:0]      csr_wdata;

   reduce_motion_tracker tracker;
   logic [TIME_BITS-1:0] cur_ts;
   int                   req_idle_pct;
   int                   rsp_idle_pct;
   bit                   hold_off_armed;

   frame_rate_reduce_motion_guard_unit #(
      .TIME_BITS  (TIME_BITS),
      .DWELL_BITS (DWELL_BITS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_timestamp_ns  (req_timestamp_ns),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fps_x16       (rsp_fps_x16),
      .rsp_low_frame     (rsp_low_frame),
      .rsp_reduce_motion (rsp_reduce_motion),
      .rsp_changed       (rsp_changed),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls, or one long hold-off when armed
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_result(rsp_fps_x16, rsp_low_frame, rsp_reduce_motion, rsp_changed);
         if (req_valid && req_ready) tracker.note_frame(req_timestamp_ns);
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_wdata);
      end
   end

   function automatic longint unsigned rand_span(longint unsigned lo, longint unsigned hi);
      return lo + ({$urandom, $urandom} % (hi - lo + 1));
   endfunction

   function automatic longint unsigned pick_interval(run_kind_type kind,
                                                     longint unsigned nominal);
      int r;
      r = $urandom_range(0, 9);
      case (kind)
         RUN_LOW: begin
            if (r == 0) return rand_span(64'd100_000_000, 64'd10_000_000_000);
            return rand_span(nominal + 1, 3 * nominal);
         end
         RUN_HIGH: begin
            if (r == 0) return nominal;
            if (r == 1) return rand_span(1, nominal);
            return rand_span(nominal / 3, nominal);
         end
         default: begin
            if (r == 0) return 0;
            if (r == 1) return rand_span(1, 244_141);
            if (r == 2) return {$urandom, $urandom};
            if (r == 3) return rand_span(64'd10_000_000_000, 64'd1_000_000_000_000);
            return rand_span(1, 2 * nominal);
         end
      endcase
   endfunction

   task automatic send_frame(input logic [TIME_BITS-1:0] ts);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_timestamp_ns <= ts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic advance(input longint unsigned d);
      cur_ts = cur_ts + d[TIME_BITS-1:0];
      send_frame(cur_ts);
   endtask

   task automatic write_csr(input logic [fgd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [fgd_pkg::REDUCE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic program_regs(input logic [fgd_pkg::CFG_W-1:0] target,
                               input logic [fgd_pkg::CFG_W-1:0] override,
                               input logic [fgd_pkg::REDUCE_W-1:0] reduce_after);
      // upper bits are junk, the block masks them
      write_csr(fgd_pkg::CSR_FPS_TARGET, {26'($urandom), target});
      write_csr(fgd_pkg::CSR_LOW_FPS_OVERRIDE, {26'($urandom), override});
      write_csr(fgd_pkg::CSR_REDUCE_AFTER_NS, reduce_after);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int              p;
      int              k;
      int              sent;
      int              run_len;
      run_kind_type    kind;
      longint unsigned nominal;

      tracker          = new();
      cur_ts           = '0;
      req_idle_pct     = 23;
      rsp_idle_pct     = 49;
      hold_off_armed   = 1'b0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_timestamp_ns <= '0;
      csr_valid        <= 1'b0;
      csr_index        <= fgd_pkg::CSR_FPS_TARGET;
      csr_wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset config: first beat, zero interval, fps saturation, threshold edge, wrap
      send_frame(cur_ts);
      advance(0);
      advance(1);
      advance(244_141);
      advance(16_666_667);
      advance(18_181_818);
      advance(18_181_819);
      cur_ts = {TIME_BITS{1'b1}};
      send_frame(cur_ts);
      advance(2);
      advance({TIME_BITS{1'b1}});

      // immediate reduce, default recovery
      settle();
      program_regs(10'd0, 10'd0, 36'd0);
      send_frame(cur_ts);
      advance(33_333_334);
      for (k = 0; k < 10; k++) advance(33_333_333);

      for (p = 0; p < N_SETTINGS; p++) begin
         if (p < 3) begin
            req_idle_pct = 23;
            rsp_idle_pct = 49;
         end else if (p < 6) begin
            req_idle_pct = 49;
            rsp_idle_pct = 23;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         settle();
         program_regs(TARGET_SET[p], OVERRIDE_SET[p], REDUCE_SET[p]);
         nominal = 64'(fgd_pkg::TEN_E10) / tracker.threshold_tenths();
         if (p == 1) hold_off_armed = 1'b1;
         sent = 0;
         while (sent < PHASE_BEATS) begin
            k = $urandom_range(0, 9);
            kind    = (k < 4) ? RUN_LOW : (k < 8) ? RUN_HIGH : RUN_NOISE;
            run_len = $urandom_range(4, 30);
            for (k = 0; k < run_len && sent < PHASE_BEATS; k++) begin
               if (p == 4 && sent == PHASE_BEATS / 2) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
                  while (tracker.expected_verdicts.size() != 0) @(posedge clock);
                  @(posedge clock);
               end
               if (p == 2 && sent == PHASE_BEATS / 2) begin
                  // out-of-range index must leave tracking intact
                  settle();
                  write_csr(CSR_UNUSED, {$urandom, $urandom});
                  csr_valid <= 1'b0;
               end
               advance(pick_interval(kind, nominal));
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_verdicts.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/fgd_pkg.sv
hw/rtl/fgd_serial.sv
hw/rtl/fgd_dwell.sv
hw/rtl/frame_rate_reduce_motion_guard_unit.sv
verif/frame_rate_reduce_motion_guard_unit_tb.sv
